// ----- hdl/sle_pkg.sv -----
// Package for the sorted list engine.
// Holds the action and status codes and the sequencer state type.
// No dependencies.
package sle_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_REMOVE    = 2'd1,
    ACT_READ_ASC  = 2'd2,
    ACT_READ_DESC = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_REM,
    S_READ,
    S_RESP
  } state_t;

endpackage

// ----- hdl/sorted_list_engine.sv -----
// Top level of the sorted list engine: sequencer, entry memory and output register.
// Depends on sle_pkg.
//
// The engine keeps up to DEPTH signed 32-bit values in ascending order in a
// single-port-write, registered-read memory and takes one input beat at a time.
// An insert walks down from the highest entry, moving each entry not smaller than
// the new value up by one, and skips the walk when the list is full or empty.
// A remove walks up from the lowest entry, moving each entry after the match
// down by one, and skips the walk on an empty list. A readout streams one
// result beat per cycle after a registered memory read, while the output side
// keeps taking beats. Each memory access is one read and one write per cycle.
// The next input beat is taken once the final result beat of the current one
// sits in the output register. No clearing pass is needed after reset.
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] item_value,
  output logic [1:0]         status,
  output logic               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] q;

  state_t             state, state_next;
  logic [AW-1:0]      idx, idx_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [CW-1:0]      k, k_next;
  logic               found, found_next;
  action_t            op, op_next;
  logic signed [31:0] val, val_next;
  status_t            resp, resp_next;

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;

  logic               out_free;
  logic               out_load;
  logic signed [31:0] out_item;
  status_t            out_st;
  logic               out_last;

  logic [CW-1:0]      cnt_m1;
  logic [AW-1:0]      last_idx;
  logic               hit;

  assign out_free = !out_valid || out_ready;
  assign cnt_m1   = cnt - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign hit      = found || (q == val);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      found <= 1'b0;
      k     <= '0;
      idx   <= '0;
      op    <= ACT_INSERT;
      resp  <= ST_OK;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      found <= found_next;
      k     <= k_next;
      idx   <= idx_next;
      op    <= op_next;
      resp  <= resp_next;
    end
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      item_value <= out_item;
      status     <= out_st;
      last       <= out_last;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    found_next = found;
    k_next     = k;
    op_next    = op;
    val_next   = val;
    resp_next  = resp;
    we         = 1'b0;
    waddr      = idx;
    wdata      = q;
    re         = 1'b0;
    raddr      = idx;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    out_item   = '0;
    out_st     = resp;
    out_last   = 1'b1;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next  = action_t'(action);
          val_next = value;
          case (action_t'(action))
            ACT_INSERT: begin
              if (cnt == CW'(DEPTH)) begin
                resp_next  = ST_FULL;
                state_next = S_RESP;
              end else if (cnt == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = value;
                cnt_next   = cnt + CW'(1);
                resp_next  = ST_OK;
                state_next = S_RESP;
              end else begin
                re         = 1'b1;
                raddr      = last_idx;
                idx_next   = last_idx;
                state_next = S_INS;
              end
            end
            ACT_REMOVE: begin
              if (cnt == '0) begin
                resp_next  = ST_NOTFOUND;
                state_next = S_RESP;
              end else begin
                re         = 1'b1;
                raddr      = '0;
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_REM;
              end
            end
            default: begin
              if (cnt == '0) begin
                resp_next  = ST_EMPTY;
                state_next = S_RESP;
              end else begin
                re         = 1'b1;
                raddr      = (action_t'(action) == ACT_READ_ASC) ? '0 : last_idx;
                idx_next   = raddr;
                k_next     = '0;
                state_next = S_READ;
              end
            end
          endcase
        end
      end

      S_INS: begin
        we    = 1'b1;
        waddr = idx + AW'(1);
        if (q >= val) begin
          wdata = q;
          if (idx == '0) begin
            state_next = S_PUT;
          end else begin
            idx_next = idx - AW'(1);
            re       = 1'b1;
            raddr    = idx - AW'(1);
          end
        end else begin
          wdata      = val;
          cnt_next   = cnt + CW'(1);
          resp_next  = ST_OK;
          state_next = S_RESP;
        end
      end

      S_PUT: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = val;
        cnt_next   = cnt + CW'(1);
        resp_next  = ST_OK;
        state_next = S_RESP;
      end

      S_REM: begin
        if (found) begin
          we    = 1'b1;
          waddr = idx - AW'(1);
          wdata = q;
        end
        found_next = hit;
        if (idx == last_idx) begin
          if (hit) begin
            cnt_next  = cnt_m1;
            resp_next = ST_OK;
          end else begin
            resp_next = ST_NOTFOUND;
          end
          state_next = S_RESP;
        end else begin
          idx_next = idx + AW'(1);
          re       = 1'b1;
          raddr    = idx + AW'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_st     = resp;
          state_next = S_IDLE;
        end
      end

      S_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          out_item = q;
          out_st   = ST_OK;
          out_last = (k == cnt_m1);
          if (k == cnt_m1) begin
            state_next = S_IDLE;
          end else begin
            k_next   = k + CW'(1);
            idx_next = (op == ACT_READ_ASC) ? idx + AW'(1) : idx - AW'(1);
            re       = 1'b1;
            raddr    = idx_next;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
